[sv/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the periodic task due scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int NUM_TASKS = 8;
    localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W     = $clog2(NUM_TASKS + 1);
    localparam int CMP_W     = (CNT_W > 3) ? CNT_W : 3;

    localparam int REQ_W   = 3;
    localparam int SLOT_W  = 3;
    localparam int TIME_W  = 32;
    localparam int EV_W    = 2;

    // Input transaction layout, lowest bit first.
    localparam int REQ_LSB    = 0;
    localparam int SLOT_LSB   = REQ_LSB + REQ_W;
    localparam int PERIOD_LSB = SLOT_LSB + SLOT_W;
    localparam int ON_LSB     = PERIOD_LSB + TIME_W;
    localparam int NOW_LSB    = ON_LSB + 1;
    localparam int S_BITS     = NOW_LSB + TIME_W;
    localparam int S_TDATA_W  = ((S_BITS + 7) / 8) * 8;

    // Output transaction layout, lowest bit first.
    localparam int EV_LSB     = 0;
    localparam int OSLOT_LSB  = EV_LSB + EV_W;
    localparam int M_BITS     = OSLOT_LSB + SLOT_W;
    localparam int M_TDATA_W  = ((M_BITS + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_POLL     = 3'd0,
        REQ_REGISTER = 3'd1,
        REQ_ENABLE   = 3'd2,
        REQ_PERIOD   = 3'd3,
        REQ_INIT     = 3'd4
    } t_req;

    typedef enum logic [EV_W-1:0] {
        EV_DUE        = 2'd0,
        EV_REGISTERED = 2'd1,
        EV_FULL       = 2'd2,
        EV_DONE       = 2'd3
    } t_ev;

endpackage

[sv/periodic_task_due_scheduler.sv]
// A non-poll request goes straight from acceptance to the response state; a poll visits
// each registered task in turn (table read, subtract, compare and write back,
// emit decision) and then goes to the response state for its final result.
// One request is taken at a time; no new request is accepted until its final result is
// registered, and any stall on the output side holds the block.
// Reset (synchronous, active low) clears the task count, enable bits and output register.
// ----------------------------------------------------------------------------
// periodic_task_due_scheduler
// Table of periodic tasks; a poll reports every enabled task whose nonzero period has elapsed.
// ----------------------------------------------------------------------------
module periodic_task_due_scheduler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // req_type[2:0], slot[5:3], period[37:6], turn_on[38], now_ms[70:39]
    input  logic [pts_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // event_res[1:0], slot_out[4:2]
    output logic [pts_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    localparam int IDX_W  = pts_pkg::IDX_W;
    localparam int CNT_W  = pts_pkg::CNT_W;
    localparam int CMP_W  = pts_pkg::CMP_W;
    localparam int TIME_W = pts_pkg::TIME_W;
    localparam int SLOT_W = pts_pkg::SLOT_W;
    localparam int NTASK  = pts_pkg::NUM_TASKS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUB,
        S_CMP,
        S_NEXT,
        S_RESP
    } t_state;

    // Unpacked input fields.
    pts_pkg::t_req     in_req;
    logic [SLOT_W-1:0] in_slot;
    logic [TIME_W-1:0] in_period;
    logic              in_on;
    logic [TIME_W-1:0] in_now;

    assign in_req    = pts_pkg::t_req'(s_tdata[pts_pkg::REQ_LSB +: pts_pkg::REQ_W]);
    assign in_slot   = s_tdata[pts_pkg::SLOT_LSB +: SLOT_W];
    assign in_period = s_tdata[pts_pkg::PERIOD_LSB +: TIME_W];
    assign in_on     = s_tdata[pts_pkg::ON_LSB];
    assign in_now    = s_tdata[pts_pkg::NOW_LSB +: TIME_W];

    // Task tables.
    logic [TIME_W-1:0] period_mem [NTASK];
    logic [TIME_W-1:0] last_mem   [NTASK];

    t_state            r_state,      n_state;
    logic [CNT_W-1:0]  r_total,      n_total;
    logic [NTASK-1:0]  r_en,         n_en;
    logic [IDX_W-1:0]  r_idx,        n_idx;
    logic [TIME_W-1:0] r_now,        n_now;
    logic [TIME_W-1:0] r_elapsed,    n_elapsed;
    logic              r_due,        n_due;
    logic              r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]  r_pend_slot,  n_pend_slot;
    pts_pkg::t_ev      r_resp_ev,    n_resp_ev;
    logic [SLOT_W-1:0] r_resp_slot,  n_resp_slot;
    logic              r_out_valid,  n_out_valid;
    pts_pkg::t_ev      r_out_ev,     n_out_ev;
    logic [SLOT_W-1:0] r_out_slot,   n_out_slot;
    logic              r_out_last,   n_out_last;
    logic [TIME_W-1:0] r_per_rd;
    logic [TIME_W-1:0] r_lr_rd;

    logic              per_we;
    logic [IDX_W-1:0]  per_waddr;
    logic [TIME_W-1:0] per_wdata;
    logic              lr_we;
    logic [IDX_W-1:0]  lr_waddr;
    logic [TIME_W-1:0] lr_wdata;

    logic              s_accept;
    logic              out_free;
    logic              slot_ok;
    logic              cmp_due;
    logic              cmp_snap;
    logic              blocked;
    logic              last_task;
    logic              np_valid;
    logic [IDX_W-1:0]  np_slot;

    assign s_tready = (r_state == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !r_out_valid || m_tready;
    assign slot_ok  = CMP_W'(in_slot) < CMP_W'(r_total);

    // Compare stage of the shared unit: the doubled period is held in 33 bits.
    assign cmp_due  = r_en[r_idx] && (r_per_rd != '0) && (r_elapsed >= r_per_rd);
    assign cmp_snap = {1'b0, r_elapsed} >= {r_per_rd, 1'b0};

    assign blocked   = r_due && r_pend_valid && !out_free;
    assign last_task = (CNT_W'(r_idx) + CNT_W'(1)) == r_total;
    assign np_valid  = r_pend_valid || r_due;
    assign np_slot   = r_due ? r_idx : r_pend_slot;

    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_en         = r_en;
        n_idx        = r_idx;
        n_now        = r_now;
        n_elapsed    = r_elapsed;
        n_due        = r_due;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_resp_ev    = r_resp_ev;
        n_resp_slot  = r_resp_slot;
        n_out_valid  = r_out_valid && !m_tready;
        n_out_ev     = r_out_ev;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;
        per_we       = 1'b0;
        per_waddr    = r_idx;
        per_wdata    = in_period;
        lr_we        = 1'b0;
        lr_waddr     = r_idx;
        lr_wdata     = in_now;

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_resp_ev   = pts_pkg::EV_DONE;
                    n_resp_slot = '0;
                    n_state     = S_RESP;
                    case (in_req)
                        pts_pkg::REQ_POLL: begin
                            n_now        = in_now;
                            n_idx        = '0;
                            n_pend_valid = 1'b0;
                            if (r_total != '0) begin
                                n_state = S_READ;
                            end
                        end
                        pts_pkg::REQ_REGISTER: begin
                            if (r_total < CNT_W'(NTASK)) begin
                                per_we    = 1'b1;
                                per_waddr = r_total[IDX_W-1:0];
                                lr_we     = 1'b1;
                                lr_waddr  = r_total[IDX_W-1:0];
                                n_en[r_total[IDX_W-1:0]] = 1'b1;
                                n_total     = r_total + CNT_W'(1);
                                n_resp_ev   = pts_pkg::EV_REGISTERED;
                                n_resp_slot = SLOT_W'(r_total);
                            end else begin
                                n_resp_ev = pts_pkg::EV_FULL;
                            end
                        end
                        pts_pkg::REQ_ENABLE: begin
                            if (slot_ok) begin
                                n_en[IDX_W'(in_slot)] = in_on;
                            end
                        end
                        pts_pkg::REQ_PERIOD: begin
                            if (slot_ok) begin
                                per_we    = 1'b1;
                                per_waddr = IDX_W'(in_slot);
                            end
                        end
                        pts_pkg::REQ_INIT: begin
                            per_we    = 1'b1;
                            per_waddr = '0;
                            lr_we     = 1'b1;
                            lr_waddr  = '0;
                            n_en      = NTASK'(1);
                            n_total   = CNT_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_SUB;
            end
            S_SUB: begin
                // Wrap-around elapsed time through the shared subtractor.
                n_elapsed = r_now - r_lr_rd;
                n_state   = S_CMP;
            end
            S_CMP: begin
                n_due    = cmp_due;
                lr_we    = cmp_due;
                lr_waddr = r_idx;
                lr_wdata = cmp_snap ? r_now : (r_lr_rd + r_per_rd);
                n_state  = S_NEXT;
            end
            S_NEXT: begin
                // One due result is held back so that the final one can carry tlast.
                if (!blocked) begin
                    if (r_due && r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_ev    = pts_pkg::EV_DUE;
                        n_out_slot  = SLOT_W'(r_pend_slot);
                        n_out_last  = 1'b0;
                    end
                    n_pend_valid = np_valid;
                    n_pend_slot  = np_slot;
                    if (last_task) begin
                        n_resp_ev    = np_valid ? pts_pkg::EV_DUE : pts_pkg::EV_DONE;
                        n_resp_slot  = np_valid ? SLOT_W'(np_slot) : '0;
                        n_pend_valid = 1'b0;
                        n_state      = S_RESP;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ev    = r_resp_ev;
                    n_out_slot  = r_resp_slot;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_total      <= '0;
            r_en         <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_en         <= n_en;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_idx       <= n_idx;
        r_now       <= n_now;
        r_elapsed   <= n_elapsed;
        r_due       <= n_due;
        r_pend_slot <= n_pend_slot;
        r_resp_ev   <= n_resp_ev;
        r_resp_slot <= n_resp_slot;
        r_out_ev    <= n_out_ev;
        r_out_slot  <= n_out_slot;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (per_we) begin
            period_mem[per_waddr] <= per_wdata;
        end
        if (lr_we) begin
            last_mem[lr_waddr] <= lr_wdata;
        end
        r_per_rd <= period_mem[r_idx];
        r_lr_rd  <= last_mem[r_idx];
    end

    assign m_tvalid = r_out_valid;
    assign m_tlast  = r_out_last;
    assign m_tdata  = pts_pkg::M_TDATA_W'({r_out_slot, r_out_ev});

endmodule

[sv/pts_checker.sv]
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the periodic task due scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [pts_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pts_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tlast
);

    logic [pts_pkg::EV_W-1:0]   ev;
    logic [pts_pkg::SLOT_W-1:0] oslot;

    assign ev    = m_tdata[pts_pkg::EV_LSB +: pts_pkg::EV_W];
    assign oslot = m_tdata[pts_pkg::OSLOT_LSB +: pts_pkg::SLOT_W];

    // A stalled result transaction holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Every request is worked on alone.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another was in progress");

    // Only a due result may be followed by further results of the same request.
    a_last_on_non_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (ev != pts_pkg::EV_DUE) |-> m_tlast)
        else $error("non-due result without tlast");

    // Done and full results report slot zero.
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && ((ev == pts_pkg::EV_DONE) || (ev == pts_pkg::EV_FULL)) |-> oslot == '0)
        else $error("done or full result with nonzero slot");

endmodule

bind periodic_task_due_scheduler pts_checker u_pts_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the periodic task due scheduler. Requests are
// queued by a generator, sent by a clocked driver with random gaps, and
// predicted on acceptance against a local copy of the task table. Each result
// transaction is checked field by field against the oldest predicted answer.
// ----------------------------------------------------------------------------
module tb;

    localparam int NUM_TASKS  = pts_pkg::NUM_TASKS;
    localparam int REQ_W      = pts_pkg::REQ_W;
    localparam int SLOT_W     = pts_pkg::SLOT_W;
    localparam int TIME_W     = pts_pkg::TIME_W;
    localparam int EV_W       = pts_pkg::EV_W;
    localparam int S_TDATA_W  = pts_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = pts_pkg::M_TDATA_W;
    localparam int REQ_LSB    = pts_pkg::REQ_LSB;
    localparam int SLOT_LSB   = pts_pkg::SLOT_LSB;
    localparam int PERIOD_LSB = pts_pkg::PERIOD_LSB;
    localparam int ON_LSB     = pts_pkg::ON_LSB;
    localparam int NOW_LSB    = pts_pkg::NOW_LSB;
    localparam int EV_LSB     = pts_pkg::EV_LSB;
    localparam int OSLOT_LSB  = pts_pkg::OSLOT_LSB;

    localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;
    localparam int TOTAL_ITEMS  = 470;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] period;
        logic              turn_on;
        logic [TIME_W-1:0] now_ms;
        bit                drain;   // hold back until every answer is in
    } t_sched_item;

    typedef struct {
        pts_pkg::t_ev      ev;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_sched_answer;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    // Local copy of the task table.
    logic [TIME_W-1:0] period_of [NUM_TASKS];
    logic [TIME_W-1:0] last_run_of [NUM_TASKS];
    logic              enabled [NUM_TASKS] = '{default: 1'b0};
    int                model_total = 0;

    t_sched_item   request_q [$];
    t_sched_answer answers_due [$];
    t_sched_item   drv_item;
    int            n_items = 0;
    int            accepted = 0;
    int            mismatches = 0;
    int            results_seen = 0;
    int            send_gap = 0;
    int            send_calm = 0;
    int            hold_cnt = 0;
    int            recv_calm = 0;
    bit            offering;
    bit            taking;

    periodic_task_due_scheduler dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // Idle length: mostly none or short, a few long, and now and then a calm
    // stretch with no idling at all.
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 3) begin
            calm = int'($urandom_range(20, 80));
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(5, 40));
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_request(input t_sched_item it);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[REQ_LSB +: REQ_W]     = it.req;
        d[SLOT_LSB +: SLOT_W]   = it.slot;
        d[PERIOD_LSB +: TIME_W] = it.period;
        d[ON_LSB]               = it.turn_on;
        d[NOW_LSB +: TIME_W]    = it.now_ms;
        return d;
    endfunction

    // Applies one request to the local table and queues the answers it causes.
    task automatic schedule_request(input t_sched_item it);
        t_sched_answer found [$];
        t_sched_answer ans;
        logic [TIME_W-1:0] elapsed;
        ans.slot = '0;
        ans.last = 1'b0;
        ans.ev   = pts_pkg::EV_DONE;
        case (it.req)
            pts_pkg::REQ_POLL: begin
                for (int i = 0; i < model_total; i++) begin
                    if (enabled[i] && period_of[i] != '0) begin
                        elapsed = it.now_ms - last_run_of[i];
                        if (elapsed >= period_of[i]) begin
                            // Twice the period is formed in 33 bits.
                            if ({1'b0, elapsed} >= {period_of[i], 1'b0})
                                last_run_of[i] = it.now_ms;
                            else
                                last_run_of[i] = last_run_of[i] + period_of[i];
                            ans.ev   = pts_pkg::EV_DUE;
                            ans.slot = SLOT_W'(i);
                            found.push_back(ans);
                        end
                    end
                end
            end
            pts_pkg::REQ_REGISTER: begin
                if (model_total < NUM_TASKS) begin
                    period_of[model_total]   = it.period;
                    last_run_of[model_total] = it.now_ms;
                    enabled[model_total]     = 1'b1;
                    ans.ev   = pts_pkg::EV_REGISTERED;
                    ans.slot = SLOT_W'(model_total);
                    model_total++;
                end else begin
                    ans.ev = pts_pkg::EV_FULL;
                end
                found.push_back(ans);
            end
            pts_pkg::REQ_ENABLE: begin
                if (int'(it.slot) < model_total) enabled[it.slot] = it.turn_on;
            end
            pts_pkg::REQ_PERIOD: begin
                if (int'(it.slot) < model_total) period_of[it.slot] = it.period;
            end
            pts_pkg::REQ_INIT: begin
                for (int i = 0; i < NUM_TASKS; i++) begin
                    period_of[i]   = '0;
                    last_run_of[i] = '0;
                    enabled[i]     = 1'b0;
                end
                period_of[0]   = it.period;
                last_run_of[0] = it.now_ms;
                enabled[0]     = 1'b1;
                model_total    = 1;
            end
            default: ;
        endcase
        if (found.size() == 0) begin
            ans.ev   = pts_pkg::EV_DONE;
            ans.slot = '0;
            found.push_back(ans);
        end
        found[found.size() - 1].last = 1'b1;
        foreach (found[k]) answers_due.push_back(found[k]);
    endtask

    task automatic report(input string msg);
        $display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_answer(input logic [M_TDATA_W-1:0] d, input logic l);
        t_sched_answer want;
        if (answers_due.size() == 0) begin
            report($sformatf("unexpected result ev=%0d slot=%0d last=%0b",
                   d[EV_LSB +: EV_W], d[OSLOT_LSB +: SLOT_W], l));
        end else begin
            want = answers_due.pop_front();
            if (d[EV_LSB +: EV_W] !== want.ev)
                report($sformatf("event_res %0d, wanted %0d", d[EV_LSB +: EV_W], want.ev));
            if (d[OSLOT_LSB +: SLOT_W] !== want.slot)
                report($sformatf("slot_out %0d, wanted %0d",
                       d[OSLOT_LSB +: SLOT_W], want.slot));
            if (l !== want.last)
                report($sformatf("last %0b, wanted %0b", l, want.last));
        end
        results_seen++;
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            offering = s_tvalid;
            if (s_tvalid && s_tready) begin
                schedule_request(drv_item);
                accepted++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_q.size() != 0 &&
                             (!request_q[0].drain || answers_due.size() == 0)) begin
                    drv_item = request_q.pop_front();
                    s_tdata <= pack_request(drv_item);
                    send_gap = idle_len(send_calm);
                    offering = 1'b1;
                end
            end
            s_tvalid <= offering;
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_answer(m_tdata, m_tlast);
            if (hold_cnt > 0) begin
                hold_cnt--;
                taking = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                hold_cnt = idle_len(recv_calm);
                taking = (hold_cnt == 0);
            end else begin
                taking = 1'b1;
            end
            m_tready <= taking;
        end
    end

    task automatic queue_request(input logic [REQ_W-1:0] req, input logic [SLOT_W-1:0] slot,
                                 input logic [TIME_W-1:0] period, input logic turn_on,
                                 input logic [TIME_W-1:0] now_ms, input bit drain);
        t_sched_item it;
        it.req     = req;
        it.slot    = slot;
        it.period  = period;
        it.turn_on = turn_on;
        it.now_ms  = now_ms;
        it.drain   = drain;
        request_q.push_back(it);
        n_items++;
    endtask

    function automatic logic [TIME_W-1:0] pick_period();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 10) return '0;
        if (r < 85) return $urandom_range(1, 40);
        if (r < 95) return $urandom_range(41, 2000);
        return $urandom();
    endfunction

    function automatic logic [TIME_W-1:0] step_clock(input logic [TIME_W-1:0] t);
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70) return t + $urandom_range(0, 15);
        if (r < 90) return t + $urandom_range(16, 300);
        if (r < 97) return t + $urandom_range(301, 100000);
        return $urandom();
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot(input int held);
        if (held == 0 || $urandom_range(0, 99) < 15) return SLOT_W'($urandom_range(0, 7));
        return SLOT_W'($urandom_range(0, held - 1));
    endfunction

    initial begin : stimulus
        logic [TIME_W-1:0] now_ms;
        int held;
        int stop_at;
        int r;
        bit drain;

        // Poll and set enable before any task exists, and an unknown request.
        queue_request(pts_pkg::REQ_POLL, 3'd0, 32'd0, 1'b0, 32'd0, 1'b0);
        queue_request(pts_pkg::REQ_ENABLE, 3'd0, 32'd0, 1'b1, 32'd1, 1'b0);
        queue_request(REQ_UNUSED_FIRST, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
        // Init just before the clock wraps; edits beyond the task count are ignored.
        queue_request(pts_pkg::REQ_INIT, 3'd5, 32'd10, 1'b0, 32'hFFFF_FFF8, 1'b0);
        queue_request(pts_pkg::REQ_PERIOD, 3'd7, 32'd3, 1'b0, 32'hFFFF_FFF9, 1'b0);
        queue_request(pts_pkg::REQ_ENABLE, 3'd1, 32'd0, 1'b1, 32'hFFFF_FFFA, 1'b0);
        queue_request(pts_pkg::REQ_POLL, 3'd0, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b0);
        queue_request(pts_pkg::REQ_POLL, 3'd0, 32'd0, 1'b0, 32'd2, 1'b0);
        // Fill the table, then one register too many.
        queue_request(pts_pkg::REQ_REGISTER, 3'd0, 32'd0, 1'b0, 32'd3, 1'b0);
        queue_request(pts_pkg::REQ_REGISTER, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'd4, 1'b0);
        queue_request(pts_pkg::REQ_REGISTER, 3'd0, 32'h8000_0000, 1'b0, 32'd5, 1'b0);
        queue_request(pts_pkg::REQ_REGISTER, 3'd0, 32'd1, 1'b0, 32'd6, 1'b0);
        queue_request(pts_pkg::REQ_REGISTER, 3'd0, 32'd2, 1'b0, 32'd6, 1'b0);
        queue_request(pts_pkg::REQ_REGISTER, 3'd0, 32'd3, 1'b0, 32'd6, 1'b0);
        queue_request(pts_pkg::REQ_REGISTER, 3'd0, 32'd4, 1'b0, 32'd6, 1'b0);
        queue_request(pts_pkg::REQ_REGISTER, 3'd0, 32'd9, 1'b0, 32'd7, 1'b1);
        // Snap after a long wait, then half-range and full-range periods.
        queue_request(pts_pkg::REQ_POLL, 3'd0, 32'd0, 1'b0, 32'd100, 1'b0);
        queue_request(pts_pkg::REQ_ENABLE, 3'd4, 32'd0, 1'b0, 32'd101, 1'b0);
        queue_request(pts_pkg::REQ_PERIOD, 3'd5, 32'd0, 1'b0, 32'd102, 1'b0);
        queue_request(pts_pkg::REQ_POLL, 3'd0, 32'd0, 1'b0, 32'h8000_0005, 1'b0);
        queue_request(pts_pkg::REQ_POLL, 3'd0, 32'd0, 1'b0, 32'd3, 1'b0);
        queue_request(REQ_UNUSED_FIRST + 3'd1, 3'd2, 32'd5, 1'b0, 32'd3, 1'b0);
        queue_request(REQ_UNUSED_LAST, 3'd3, 32'd6, 1'b1, 32'd4, 1'b0);
        queue_request(pts_pkg::REQ_ENABLE, 3'd4, 32'd0, 1'b1, 32'd4, 1'b0);
        queue_request(pts_pkg::REQ_POLL, 3'd0, 32'd0, 1'b0, 32'd10, 1'b0);

        // Random episodes: init, a few registers, then a body that is mostly
        // polls with edits, stray requests and noise mixed in.
        now_ms  = $urandom();
        stop_at = TOTAL_ITEMS;
        drain   = 1'b1;
        while (n_items < stop_at) begin
            now_ms = step_clock(now_ms);
            queue_request(pts_pkg::REQ_INIT, SLOT_W'($urandom_range(0, 7)), pick_period(),
                          1'($urandom_range(0, 1)), now_ms, drain);
            held = 1;
            repeat ($urandom_range(0, 8)) begin
                now_ms = now_ms + $urandom_range(0, 5);
                queue_request(pts_pkg::REQ_REGISTER, SLOT_W'($urandom_range(0, 7)),
                              pick_period(), 1'($urandom_range(0, 1)), now_ms,
                              $urandom_range(0, 49) == 0);
                if (held < NUM_TASKS) held++;
            end
            repeat ($urandom_range(10, 40)) begin
                now_ms = step_clock(now_ms);
                drain  = ($urandom_range(0, 49) == 0);
                r = int'($urandom_range(0, 99));
                if (r < 60) begin
                    queue_request(pts_pkg::REQ_POLL, SLOT_W'($urandom_range(0, 7)), $urandom(),
                                  1'($urandom_range(0, 1)), now_ms, drain);
                end else if (r < 70) begin
                    queue_request(pts_pkg::REQ_ENABLE, pick_slot(held), $urandom(),
                                  $urandom_range(0, 3) != 0, now_ms, drain);
                end else if (r < 80) begin
                    queue_request(pts_pkg::REQ_PERIOD, pick_slot(held), pick_period(),
                                  1'($urandom_range(0, 1)), now_ms, drain);
                end else if (r < 87) begin
                    queue_request(pts_pkg::REQ_REGISTER, SLOT_W'($urandom_range(0, 7)),
                                  pick_period(), 1'($urandom_range(0, 1)), now_ms, drain);
                    if (held < NUM_TASKS) held++;
                end else if (r < 92) begin
                    queue_request(REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)),
                                  SLOT_W'($urandom_range(0, 7)), $urandom(),
                                  1'($urandom_range(0, 1)), $urandom(), drain);
                end else begin
                    queue_request($urandom_range(0, 1) ? pts_pkg::REQ_ENABLE
                                                       : pts_pkg::REQ_PERIOD,
                                  SLOT_W'($urandom_range(0, 7)), $urandom(),
                                  1'($urandom_range(0, 1)), now_ms, drain);
                end
            end
            drain = ($urandom_range(0, 9) == 0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted != n_items || answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
